// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the deque checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define DEQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, held off during reset
`define DEQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

// File: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared constants and codes for the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 5;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_QUERY      = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

	// word shown when nothing is there
	localparam logic [WORD_W-1:0] NONE_WORD = {WORD_W{1'b1}};

endpackage

`default_nettype wire

// File: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// double-ended queue of 32-bit words in a ring ram, one result per command
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  command   start in, busy out   func, value
//  result    done out (strobe)    status, removed_word, front_word, rear_word,
//                                 occupancy, is_empty
//
//  per command, the accept cycle updates pointers, writes the
//  ram on a push and issues the ram read of the new end word on a pop; the
//  next cycle shows the result with done while busy is high.
//  front and rear words are cached; a pop reloads one from the ram read.
//  arst_n clears pointers, count and control; ram contents are not cleared.
//  the receiver cannot stall, each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [deq_pkg::FUNC_W-1:0]            func,
	input  logic signed [deq_pkg::WORD_W-1:0]     value,
	output logic                                  done,
	output logic [deq_pkg::STATUS_W-1:0]          status,
	output logic signed [deq_pkg::WORD_W-1:0]     removed_word,
	output logic signed [deq_pkg::WORD_W-1:0]     front_word,
	output logic signed [deq_pkg::WORD_W-1:0]     rear_word,
	output logic [deq_pkg::OCC_W-1:0]             occupancy,
	output logic                                  is_empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

	typedef enum logic {S_IDLE, S_RESP} state_t;

	state_t                         state_q;
	logic [AW-1:0]                  front_slot_q;
	logic [AW-1:0]                  rear_slot_q;
	logic [CW-1:0]                  count_q;
	logic                           ld_front_q;
	logic                           ld_rear_q;
	logic [deq_pkg::STATUS_W-1:0]   status_q;
	logic [deq_pkg::WORD_W-1:0]     removed_q;
	logic [deq_pkg::WORD_W-1:0]     front_word_q;
	logic [deq_pkg::WORD_W-1:0]     rear_word_q;

	logic                           accept;
	logic                           empty_c;
	logic                           full_c;
	logic [AW-1:0]                  front_inc;
	logic [AW-1:0]                  front_dec;
	logic [AW-1:0]                  rear_inc;
	logic [AW-1:0]                  rear_dec;

	logic                           we_c;
	logic [AW-1:0]                  waddr_c;
	logic [AW-1:0]                  raddr_c;
	logic [AW-1:0]                  nxt_front;
	logic [AW-1:0]                  nxt_rear;
	logic [CW-1:0]                  nxt_count;
	logic [deq_pkg::STATUS_W-1:0]   nxt_status;
	logic [deq_pkg::WORD_W-1:0]     nxt_removed;
	logic                           ld_front_c;
	logic                           ld_rear_c;
	logic                           set_front_c;
	logic                           set_rear_c;
	logic [deq_pkg::WORD_W-1:0]     mem_rdata;

	assign accept    = start && (state_q == S_IDLE);
	assign empty_c   = (count_q == '0);
	assign full_c    = (count_q == FULL_CNT);
	assign front_inc = (front_slot_q == LAST_SLOT) ? '0 : front_slot_q + AW'(1);
	assign front_dec = (front_slot_q == '0) ? LAST_SLOT : front_slot_q - AW'(1);
	assign rear_inc  = (rear_slot_q == LAST_SLOT) ? '0 : rear_slot_q + AW'(1);
	assign rear_dec  = (rear_slot_q == '0) ? LAST_SLOT : rear_slot_q - AW'(1);

	always_comb begin
		we_c        = 1'b0;
		waddr_c     = rear_slot_q;
		raddr_c     = front_slot_q;
		nxt_front   = front_slot_q;
		nxt_rear    = rear_slot_q;
		nxt_count   = count_q;
		nxt_status  = deq_pkg::ST_OK;
		nxt_removed = deq_pkg::NONE_WORD;
		ld_front_c  = 1'b0;
		ld_rear_c   = 1'b0;
		set_front_c = 1'b0;
		set_rear_c  = 1'b0;
		case (func)
			deq_pkg::FN_PUSH_REAR: begin
				if (full_c) begin
					nxt_status = deq_pkg::ST_OVER;
				end else begin
					we_c        = 1'b1;
					nxt_rear    = rear_inc;
					waddr_c     = rear_inc;
					nxt_count   = count_q + CW'(1);
					set_rear_c  = 1'b1;
					set_front_c = empty_c;
				end
			end
			deq_pkg::FN_PUSH_FRONT: begin
				if (full_c) begin
					nxt_status = deq_pkg::ST_OVER;
				end else begin
					we_c        = 1'b1;
					nxt_front   = front_dec;
					waddr_c     = front_dec;
					nxt_count   = count_q + CW'(1);
					set_front_c = 1'b1;
					set_rear_c  = empty_c;
				end
			end
			deq_pkg::FN_POP_FRONT: begin
				if (empty_c) begin
					nxt_status = deq_pkg::ST_UNDER;
				end else begin
					nxt_removed = front_word_q;
					nxt_front   = front_inc;
					raddr_c     = front_inc;
					nxt_count   = count_q - CW'(1);
					ld_front_c  = 1'b1;
				end
			end
			deq_pkg::FN_POP_REAR: begin
				if (empty_c) begin
					nxt_status = deq_pkg::ST_UNDER;
				end else begin
					nxt_removed = rear_word_q;
					nxt_rear    = rear_dec;
					raddr_c     = rear_dec;
					nxt_count   = count_q - CW'(1);
					ld_rear_c   = 1'b1;
				end
			end
			default: begin
				// query and unused codes change nothing
			end
		endcase
	end

	deq_ram #(
		.WIDTH (deq_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && we_c),
		.waddr (waddr_c),
		.wdata (value),
		.raddr (raddr_c),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_slot_q <= '0;
			rear_slot_q  <= LAST_SLOT;
			count_q      <= '0;
			ld_front_q   <= 1'b0;
			ld_rear_q    <= 1'b0;
			status_q     <= deq_pkg::ST_OK;
			removed_q    <= deq_pkg::NONE_WORD;
			front_word_q <= deq_pkg::NONE_WORD;
			rear_word_q  <= deq_pkg::NONE_WORD;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q      <= S_RESP;
						front_slot_q <= nxt_front;
						rear_slot_q  <= nxt_rear;
						count_q      <= nxt_count;
						ld_front_q   <= ld_front_c;
						ld_rear_q    <= ld_rear_c;
						status_q     <= nxt_status;
						removed_q    <= nxt_removed;
						if (set_front_c) begin
							front_word_q <= value;
						end
						if (set_rear_c) begin
							rear_word_q <= value;
						end
					end
				end
				S_RESP: begin
					state_q    <= S_IDLE;
					ld_front_q <= 1'b0;
					ld_rear_q  <= 1'b0;
					if (ld_front_q) begin
						front_word_q <= mem_rdata;
					end
					if (ld_rear_q) begin
						rear_word_q <= mem_rdata;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q == S_RESP);
	assign done         = (state_q == S_RESP);
	assign status       = status_q;
	assign removed_word = removed_q;
	assign is_empty     = empty_c;
	assign occupancy    = deq_pkg::OCC_W'(count_q);
	assign front_word   = empty_c ? deq_pkg::NONE_WORD :
		(ld_front_q ? mem_rdata : front_word_q);
	assign rear_word    = empty_c ? deq_pkg::NONE_WORD :
		(ld_rear_q ? mem_rdata : rear_word_q);

endmodule

`default_nettype wire

// File: rtl/deq_chk.sv
// ----------------------------------------------------------------------------
// deq_chk
// port-level checks on the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module deq_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic                              done,
	input  logic [deq_pkg::STATUS_W-1:0]      status,
	input  logic signed [deq_pkg::WORD_W-1:0] removed_word,
	input  logic signed [deq_pkg::WORD_W-1:0] front_word,
	input  logic signed [deq_pkg::WORD_W-1:0] rear_word,
	input  logic                              is_empty
);

	// every accepted command gives its result in the next cycle
	`DEQ_ASSERT_NXT(a_result_follows, start && !busy, done)

	// empty queue shows no end words
	`DEQ_ASSERT_IMP(a_empty_ends, done && is_empty, front_word == deq_pkg::NONE_WORD && rear_word == deq_pkg::NONE_WORD)

	// underflow only on an empty queue and removes nothing
	`DEQ_ASSERT_IMP(a_under_empty, done && status == deq_pkg::ST_UNDER, is_empty && removed_word == deq_pkg::NONE_WORD)

	// overflow never leaves the queue empty
	`DEQ_ASSERT_IMP(a_over_full, done && status == deq_pkg::ST_OVER, !is_empty && removed_word == deq_pkg::NONE_WORD)

endmodule

bind double_ended_queue_top deq_chk u_deq_chk (.*);

`default_nettype wire
